[rtl/lcgx_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the LCG keystream XOR cipher.
// Used by the controller, the datapath and the top level.
package lcgx_pkg;

  localparam int WordW  = 32;
  localparam int ByteW  = 8;
  localparam int CfgIdxW = 2;
  localparam int CntW   = $clog2(WordW);

  localparam logic [CfgIdxW-1:0] CFG_SEED = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MULT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INCR = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MOD  = 2'd3;

  localparam logic [WordW-1:0] MOD_RESET = 32'd1;
  localparam logic [ByteW-1:0] LOW_BYTE_MASK = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DIV
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic pend_load;  // latch keystream word and result byte of an accepted transfer
    logic out_load;   // move pending byte into the output register
    logic mul;        // register the wrapped product
    logic add;        // form the sum and seed the divider
    logic store_sum;  // modulus zero: sum is the next word
    logic div_step;   // one restoring remainder step
    logic div_last;   // last step: write the remainder back as the next word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mod_zero;
  } status_t;

endpackage

[rtl/lcg_keystream_xor_cipher_unit.sv]
`timescale 1ns / 1ps
// LCG keystream XOR cipher, top level: controller plus datapath.
// Depends on lcgx_pkg, lcgx_ctrl and lcgx_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one text byte and a restart
//   flag; restart loads the seed as the keystream word for that byte.
//   Output channel (out_valid / out_stall) returns the byte XOR the low byte
//   of the keystream word, one result per input, in order.
//   Configuration: write cfg_wdata to register cfg_index (0 seed, 1 multiplier,
//   2 increment, 3 modulus) with cfg_we; write only while the block is idle.
// Sequence:
//   out_valid rises once the result byte has moved from the pending byte
//   register into the output register. The next input is taken only after
//   the accept, the 32x32 multiply, the add and the bit-serial remainder unit
//   (skipped when the modulus is zero) are done and the pending byte has
//   moved into the output register.
// Reset (rst_n low, synchronous) clears the keystream word, loads the
// register reset values and empties the output. While the receiver stalls
// the result holds; one more result waits internally, then the input stalls.
module lcg_keystream_xor_cipher_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lcgx_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lcgx_pkg::WordW-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lcgx_pkg::ByteW-1:0]   in_text_byte,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lcgx_pkg::ByteW-1:0]   out_byte
);
  import lcgx_pkg::*;

  cmd_t    cmd;
  status_t status;

  lcgx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lcgx_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_text_byte (in_text_byte),
    .in_restart   (in_restart),
    .out_byte     (out_byte),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

[rtl/lcgx_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the LCG keystream XOR cipher: sequencing of the
// multiply, add and bit-serial remainder, and the output handshake. Uses lcgx_pkg.
module lcgx_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  lcgx_pkg::status_t status,
  output lcgx_pkg::cmd_t    cmd
);
  import lcgx_pkg::*;

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            out_free;
  logic            last_step;

  assign in_stall  = (state_r != ST_IDLE) || pend_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign last_step = (cnt_r == CntW'(WordW - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cnt_nxt   = '0;
        state_nxt = status.mod_zero ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CntW'(1);
        if (last_step) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.pend_load = accept;
    cmd.out_load  = pend_valid_r && out_free;
    unique case (state_r)
      ST_IDLE: ;
      ST_MUL:  cmd.mul = 1'b1;
      ST_ADD: begin
        cmd.add       = 1'b1;
        cmd.store_sum = status.mod_zero;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = last_step;
      end
      default: ;
    endcase
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (accept) pend_valid_nxt = 1'b1;
    else if (cmd.out_load) pend_valid_nxt = 1'b0;
    // hold the output while the receiver stalls, refill from the pending byte
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

[rtl/lcgx_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the LCG keystream XOR cipher: configuration registers, keystream
// word, multiplier, adder, restoring remainder unit and byte registers. Uses lcgx_pkg.
module lcgx_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lcgx_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lcgx_pkg::WordW-1:0]  cfg_wdata,
  input  logic [lcgx_pkg::ByteW-1:0]  in_text_byte,
  input  logic                        in_restart,
  output logic [lcgx_pkg::ByteW-1:0]  out_byte,
  input  lcgx_pkg::cmd_t              cmd,
  output lcgx_pkg::status_t           status
);
  import lcgx_pkg::*;

  logic [WordW-1:0] seed_r, mult_r, incr_r, mod_r;
  logic [WordW-1:0] word_r, word_nxt;
  logic [WordW-1:0] opnd_r;
  logic [WordW-1:0] prod_r;
  logic [WordW-1:0] dvd_r;
  logic [WordW-1:0] rem_r, rem_nxt;
  logic [ByteW-1:0] pend_byte_r;
  logic [ByteW-1:0] out_byte_r;
  logic [WordW-1:0] word_cur;
  logic [WordW-1:0] sum;
  logic [WordW:0]   trial;
  logic [WordW:0]   diff;

  assign status.mod_zero = (mod_r == '0);
  assign out_byte        = out_byte_r;

  assign word_cur = in_restart ? seed_r : word_r;
  assign sum      = prod_r + incr_r;

  // restoring step: bring in the next dividend bit, subtract when it fits
  assign trial = {rem_r, dvd_r[WordW-1]};
  assign diff  = trial - {1'b0, mod_r};
  assign rem_nxt = diff[WordW] ? trial[WordW-1:0] : diff[WordW-1:0];

  always_comb begin
    word_nxt = word_r;
    if (cmd.pend_load) word_nxt = word_cur;
    else if (cmd.store_sum) word_nxt = sum;
    else if (cmd.div_last) word_nxt = rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      mult_r <= '0;
      incr_r <= '0;
      mod_r  <= MOD_RESET;
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEED: seed_r <= cfg_wdata;
          CFG_MULT: mult_r <= cfg_wdata;
          CFG_INCR: incr_r <= cfg_wdata;
          CFG_MOD:  mod_r  <= cfg_wdata;
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      opnd_r      <= word_cur;
      pend_byte_r <= in_text_byte ^ (word_cur[ByteW-1:0] & LOW_BYTE_MASK);
    end
    if (cmd.out_load) out_byte_r <= pend_byte_r;
    if (cmd.mul) prod_r <= WordW'(mult_r * opnd_r);
    if (cmd.add) begin
      dvd_r <= sum;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[WordW-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

endmodule
